[sv/rtat_pkg.sv]
package rtat_pkg;

  localparam int DIST_W      = 16;
  localparam int ANG_W       = 10;
  localparam int SUM_W       = 12;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_LANES   = 4;
  localparam int PROD_W      = ANG_W + DIST_W;
  // One quotient bit per division stage; every quotient here is below 2**ANG_W.
  localparam int DIV_STEPS   = ANG_W;
  // Operand prep, multiply, division steps, final correction.
  localparam int LANE_STAGES = DIV_STEPS + 3;

  localparam int LANE_FRONT = 0;
  localparam int LANE_RIGHT = 1;
  localparam int LANE_BACK  = 2;
  localparam int LANE_LEFT  = 3;

  localparam logic [DIST_W-1:0] START_THR_RST = 16'd2000;
  localparam logic [ANG_W-1:0]  START_ANG_RST = 10'd40;
  localparam logic [DIST_W-1:0] MID_THR_RST   = 16'd1000;
  localparam logic [ANG_W-1:0]  MID_ANG_RST   = 10'd80;
  localparam logic [DIST_W-1:0] MAX_THR_RST   = 16'd400;
  localparam logic [ANG_W-1:0]  MAX_ANG_RST   = 10'd80;
  localparam logic [DIST_W-1:0] END_THR_RST   = 16'd20;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_THR = 3'd0,
    REG_START_ANG = 3'd1,
    REG_MID_THR   = 3'd2,
    REG_MID_ANG   = 3'd3,
    REG_MAX_THR   = 3'd4,
    REG_MAX_ANG   = 3'd5,
    REG_END_THR   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [DIST_W-1:0] start_thr;
    logic [ANG_W-1:0]  start_ang;
    logic [DIST_W-1:0] mid_thr;
    logic [ANG_W-1:0]  mid_ang;
    logic [DIST_W-1:0] max_thr;
    logic [ANG_W-1:0]  max_ang;
    logic [DIST_W-1:0] end_thr;
  } cfg_t;

endpackage

[sv/rtat_ifs.sv]
interface rtat_in_if;
  logic                       valid;
  logic                       ready;
  logic [rtat_pkg::DIST_W-1:0] range_front;
  logic [rtat_pkg::DIST_W-1:0] range_right;
  logic [rtat_pkg::DIST_W-1:0] range_back;
  logic [rtat_pkg::DIST_W-1:0] range_left;
  logic [rtat_pkg::NUM_LANES-1:0] enable_mask;

  modport source (output valid, range_front, range_right, range_back, range_left,
                  enable_mask, input ready);
  modport sink (input valid, range_front, range_right, range_back, range_left,
                enable_mask, output ready);
endinterface

interface rtat_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rtat_pkg::SUM_W-1:0] roll_angle;
  logic signed [rtat_pkg::SUM_W-1:0] pitch_angle;

  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface rtat_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtat_pkg::REG_IDX_W-1:0]  index;
  logic [rtat_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/rtat_cfg_regs.sv]
module rtat_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  rtat_cfg_if.sink        cfg_i,
  output rtat_pkg::cfg_t  cfg_o
);

  rtat_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (rtat_pkg::reg_idx_e'(cfg_i.index))
        rtat_pkg::REG_START_THR: cfg_d.start_thr = cfg_i.data;
        rtat_pkg::REG_START_ANG: cfg_d.start_ang = cfg_i.data[rtat_pkg::ANG_W-1:0];
        rtat_pkg::REG_MID_THR:   cfg_d.mid_thr   = cfg_i.data;
        rtat_pkg::REG_MID_ANG:   cfg_d.mid_ang   = cfg_i.data[rtat_pkg::ANG_W-1:0];
        rtat_pkg::REG_MAX_THR:   cfg_d.max_thr   = cfg_i.data;
        rtat_pkg::REG_MAX_ANG:   cfg_d.max_ang   = cfg_i.data[rtat_pkg::ANG_W-1:0];
        rtat_pkg::REG_END_THR:   cfg_d.end_thr   = cfg_i.data;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_thr <= rtat_pkg::START_THR_RST;
      cfg_q.start_ang <= rtat_pkg::START_ANG_RST;
      cfg_q.mid_thr   <= rtat_pkg::MID_THR_RST;
      cfg_q.mid_ang   <= rtat_pkg::MID_ANG_RST;
      cfg_q.max_thr   <= rtat_pkg::MAX_THR_RST;
      cfg_q.max_ang   <= rtat_pkg::MAX_ANG_RST;
      cfg_q.end_thr   <= rtat_pkg::END_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[sv/rtat_lane.sv]
module rtat_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  rtat_pkg::cfg_t                cfg_i,
  input  logic [rtat_pkg::DIST_W-1:0]   range_i,
  input  logic                          enable_i,
  output logic [rtat_pkg::ANG_W-1:0]    angle_o
);

  localparam int DistW  = rtat_pkg::DIST_W;
  localparam int AngW   = rtat_pkg::ANG_W;
  localparam int ProdW  = rtat_pkg::PROD_W;
  localparam int Steps  = rtat_pkg::DIV_STEPS;

  // Operand prep stage.
  logic [AngW-1:0]  mul_a_d, mul_a_q;
  logic [DistW-1:0] mul_b_d, mul_b_q;
  logic [DistW-1:0] den_d, den0_q;
  logic             neg_d, neg0_q;
  logic [AngW-1:0]  off_d, off0_q;
  logic             byp_d, byp0_q;
  logic [AngW-1:0]  bval_d, bval0_q;

  logic             in_win, ramp1, ramp2;
  logic signed [AngW:0] ang_diff;

  // Division pipeline; entry 0 is the multiply stage output.
  logic [ProdW-1:0] rem_q  [Steps+1];
  logic [AngW-1:0]  quo_q  [Steps+1];
  logic [DistW-1:0] den_q  [Steps+1];
  logic             neg_q  [Steps+1];
  logic [AngW-1:0]  off_q  [Steps+1];
  logic             byp_q  [Steps+1];
  logic [AngW-1:0]  bval_q [Steps+1];

  logic [ProdW-1:0] den_sh   [Steps];
  logic             fits     [Steps];
  logic [ProdW-1:0] rem_nxt  [Steps];
  logic [AngW-1:0]  quo_nxt  [Steps];

  logic [AngW:0]    ang_d;
  logic [AngW-1:0]  angle_q;
  logic             rem_nz;

  always_comb begin
    in_win   = enable_i && (range_i < cfg_i.start_thr) && (range_i > cfg_i.end_thr);
    ramp1    = in_win && (range_i > cfg_i.mid_thr);
    ramp2    = in_win && !ramp1 && (range_i > cfg_i.max_thr);
    ang_diff = $signed({1'b0, cfg_i.mid_ang}) - $signed({1'b0, cfg_i.start_ang});

    mul_a_d = '0;
    mul_b_d = '0;
    den_d   = '0;
    neg_d   = 1'b0;
    off_d   = '0;
    byp_d   = 1'b1;
    bval_d  = '0;
    if (ramp1) begin
      mul_a_d = cfg_i.start_ang;
      mul_b_d = cfg_i.start_thr - range_i;
      den_d   = cfg_i.start_thr - cfg_i.mid_thr;
      byp_d   = 1'b0;
    end else if (ramp2) begin
      // The product is negative when mid_angle lies below start_angle.
      neg_d   = ang_diff[AngW];
      mul_a_d = ang_diff[AngW] ? AngW'(-ang_diff) : ang_diff[AngW-1:0];
      mul_b_d = cfg_i.mid_thr - range_i;
      den_d   = cfg_i.mid_thr - cfg_i.max_thr;
      off_d   = cfg_i.start_ang;
      byp_d   = 1'b0;
    end else if (in_win) begin
      bval_d  = cfg_i.max_ang;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      den_sh[k]  = {{(ProdW-DistW){1'b0}}, den_q[k]} << (Steps - 1 - k);
      fits[k]    = rem_q[k] >= den_sh[k];
      rem_nxt[k] = fits[k] ? (rem_q[k] - den_sh[k]) : rem_q[k];
      quo_nxt[k] = quo_q[k] | ({{(AngW-1){1'b0}}, fits[k]} << (Steps - 1 - k));
    end
  end

  // A negative quotient is floored: subtract one more when the remainder is nonzero.
  always_comb begin
    rem_nz = rem_q[Steps] != '0;
    if (byp_q[Steps]) begin
      ang_d = {1'b0, bval_q[Steps]};
    end else if (neg_q[Steps]) begin
      ang_d = {1'b0, off_q[Steps]} - {1'b0, quo_q[Steps]} - {{AngW{1'b0}}, rem_nz};
    end else begin
      ang_d = {1'b0, off_q[Steps]} + {1'b0, quo_q[Steps]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      den0_q  <= den_d;
      neg0_q  <= neg_d;
      off0_q  <= off_d;
      byp0_q  <= byp_d;
      bval0_q <= bval_d;

      rem_q[0]  <= ProdW'(mul_a_q) * ProdW'(mul_b_q);
      quo_q[0]  <= '0;
      den_q[0]  <= den0_q;
      neg_q[0]  <= neg0_q;
      off_q[0]  <= off0_q;
      byp_q[0]  <= byp0_q;
      bval_q[0] <= bval0_q;

      for (int k = 0; k < Steps; k++) begin
        rem_q[k+1]  <= rem_nxt[k];
        quo_q[k+1]  <= quo_nxt[k];
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        off_q[k+1]  <= off_q[k];
        byp_q[k+1]  <= byp_q[k];
        bval_q[k+1] <= bval_q[k];
      end

      angle_q <= ang_d[AngW-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

[sv/rtat_merge.sv]
module rtat_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rtat_pkg::ANG_W-1:0]  angle_i [rtat_pkg::NUM_LANES],
  output logic                        ready_o,
  rtat_out_if.source                  out_o
);

  localparam int SumW = rtat_pkg::SUM_W;
  localparam int Pad  = rtat_pkg::SUM_W - rtat_pkg::ANG_W;

  logic signed [SumW-1:0] roll_sum, pitch_sum;
  logic                   out_v_q, out_v_d, sk_v_q, sk_v_d;
  logic signed [SumW-1:0] out_roll_q, out_roll_d, out_pitch_q, out_pitch_d;
  logic signed [SumW-1:0] sk_roll_q, sk_roll_d, sk_pitch_q, sk_pitch_d;
  logic                   take, arrive;

  always_comb begin
    roll_sum  = $signed({{Pad{1'b0}}, angle_i[rtat_pkg::LANE_LEFT]})
              - $signed({{Pad{1'b0}}, angle_i[rtat_pkg::LANE_RIGHT]});
    pitch_sum = $signed({{Pad{1'b0}}, angle_i[rtat_pkg::LANE_BACK]})
              - $signed({{Pad{1'b0}}, angle_i[rtat_pkg::LANE_FRONT]});
  end

  // The lanes only advance while the skid register is empty.
  assign ready_o = !sk_v_q;
  assign take    = out_v_q && out_o.ready;
  assign arrive  = valid_i && !sk_v_q;

  always_comb begin
    out_v_d     = out_v_q;
    out_roll_d  = out_roll_q;
    out_pitch_d = out_pitch_q;
    sk_v_d      = sk_v_q;
    sk_roll_d   = sk_roll_q;
    sk_pitch_d  = sk_pitch_q;
    if (take) begin
      out_v_d = sk_v_q;
      if (sk_v_q) begin
        out_roll_d  = sk_roll_q;
        out_pitch_d = sk_pitch_q;
        sk_v_d      = 1'b0;
      end
    end
    if (arrive) begin
      if (!out_v_q || take) begin
        out_v_d     = 1'b1;
        out_roll_d  = roll_sum;
        out_pitch_d = pitch_sum;
      end else begin
        sk_v_d     = 1'b1;
        sk_roll_d  = roll_sum;
        sk_pitch_d = pitch_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_roll_q  <= out_roll_d;
    out_pitch_q <= out_pitch_d;
    sk_roll_q   <= sk_roll_d;
    sk_pitch_q  <= sk_pitch_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.roll_angle  = out_roll_q;
  assign out_o.pitch_angle = out_pitch_q;

endmodule

[sv/range_to_avoidance_tilt_top.sv]
// Throughput: one transaction per cycle while the skid register is empty; each of the
// four lanes runs a 13-stage pipeline (operand prep, multiply, ten one-bit restoring
// division stages, floor correction); the merged result is then registered at the output.
// The output register and a skid register keep input acceptance going while a result waits.
// Reset clears all valid bits and loads the threshold and angle registers with their
// defaults; the block accepts transactions as soon as reset is released.
module range_to_avoidance_tilt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtat_in_if.sink     in_i,
  rtat_cfg_if.sink    cfg_i,
  rtat_out_if.source  out_o
);

  localparam int Lanes  = rtat_pkg::NUM_LANES;
  localparam int Stages = rtat_pkg::LANE_STAGES;

  rtat_pkg::cfg_t              cfg;
  logic                        en;
  logic [Stages-1:0]           valid_q, valid_d;
  logic [rtat_pkg::DIST_W-1:0] lane_range [Lanes];
  logic [rtat_pkg::ANG_W-1:0]  lane_angle [Lanes];

  rtat_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign in_i.ready = en;

  always_comb begin
    lane_range[rtat_pkg::LANE_FRONT] = in_i.range_front;
    lane_range[rtat_pkg::LANE_RIGHT] = in_i.range_right;
    lane_range[rtat_pkg::LANE_BACK]  = in_i.range_back;
    lane_range[rtat_pkg::LANE_LEFT]  = in_i.range_left;
  end

  always_comb begin
    valid_d = valid_q;
    if (en) begin
      valid_d = {valid_q[Stages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    rtat_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .cfg_i    (cfg),
      .range_i  (lane_range[g]),
      .enable_i (in_i.enable_mask[g]),
      .angle_o  (lane_angle[g])
    );
  end

  rtat_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[Stages-1]),
    .angle_i (lane_angle),
    .ready_o (en),
    .out_o   (out_o)
  );

endmodule

[dv/range_to_avoidance_tilt_top_tb.sv]
`timescale 1ns / 1ps

module range_to_avoidance_tilt_top_tb;
  import rtat_pkg::*;

  localparam int LATENCY         = 14;
  localparam int NUM_REGS        = 7;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int HOLD_CYCLES     = 48;
  localparam int CYCLE_LIMIT     = 40000;
  localparam logic [REG_IDX_W-1:0] REG_IDX_NONE = 3'd7;

  typedef struct packed {
    logic [DIST_W-1:0]    front;
    logic [DIST_W-1:0]    right;
    logic [DIST_W-1:0]    back;
    logic [DIST_W-1:0]    left;
    logic [NUM_LANES-1:0] mask;
  } reading_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] roll;
    logic signed [SUM_W-1:0] pitch;
  } tilt_t;

  typedef struct {
    reading_t rd;
    bit       known;
    tilt_t    tilt;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rtat_in_if  in_if ();
  rtat_cfg_if cfg_if ();
  rtat_out_if out_if ();

  range_to_avoidance_tilt_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t     tilt_cfg;
  tilt_t    tilt_q[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt   = 0;
  int       cycle_cnt      = 0;
  int       in_gap_odds    = 0;
  int       out_stall_odds = 0;
  bit       hold_req       = 1'b0;

  function automatic longint floor_quot(input longint num, input longint den);
    if (den <= 0) return 0;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint lane_tilt(input logic [DIST_W-1:0] dist_mm);
    longint d, st, sa, mt, ma, xt, xa, et;
    d  = dist_mm;
    st = tilt_cfg.start_thr;
    sa = tilt_cfg.start_ang;
    mt = tilt_cfg.mid_thr;
    ma = tilt_cfg.mid_ang;
    xt = tilt_cfg.max_thr;
    xa = tilt_cfg.max_ang;
    et = tilt_cfg.end_thr;
    if (!(d < st && d > et)) return 0;
    if (d > mt) return floor_quot(sa * (st - d), st - mt);
    if (d > xt) return floor_quot((ma - sa) * (mt - d), mt - xt) + sa;
    return xa;
  endfunction

  function automatic tilt_t predict_tilt(input reading_t rd);
    longint roll, pitch;
    tilt_t  t;
    roll  = 0;
    pitch = 0;
    if (rd.mask[LANE_FRONT]) pitch -= lane_tilt(rd.front);
    if (rd.mask[LANE_RIGHT]) roll  -= lane_tilt(rd.right);
    if (rd.mask[LANE_BACK])  pitch += lane_tilt(rd.back);
    if (rd.mask[LANE_LEFT])  roll  += lane_tilt(rd.left);
    t.roll  = roll[SUM_W-1:0];
    t.pitch = pitch[SUM_W-1:0];
    return t;
  endfunction

  // Distances cluster around the active window and the threshold boundaries.
  function automatic logic [DIST_W-1:0] pick_range();
    int                hi;
    logic [DIST_W-1:0] near;
    case ($urandom_range(0, 9))
      0, 1: return DIST_W'($urandom);
      2, 3: begin
        case ($urandom_range(0, 3))
          0: near = tilt_cfg.start_thr;
          1: near = tilt_cfg.mid_thr;
          2: near = tilt_cfg.max_thr;
          default: near = tilt_cfg.end_thr;
        endcase
        return near + DIST_W'($urandom_range(0, 2)) - 16'd1;
      end
      default: begin
        hi = int'(tilt_cfg.start_thr) + int'(tilt_cfg.start_thr) / 4 + 1;
        if (hi > 65535) hi = 65535;
        return DIST_W'($urandom_range(0, hi));
      end
    endcase
  endfunction

  task automatic add_row(input int front, input int right, input int back, input int left,
                         input int mask, input bit known, input int roll, input int pitch);
    dir_row_t row;
    row.rd         = '{DIST_W'(front), DIST_W'(right), DIST_W'(back), DIST_W'(left),
                       NUM_LANES'(mask)};
    row.known      = known;
    row.tilt.roll  = SUM_W'(roll);
    row.tilt.pitch = SUM_W'(pitch);
    dir_rows.push_back(row);
  endtask

  // Entered and left at a falling edge.
  task automatic send_reading(input reading_t rd, input bit known, input tilt_t tilt);
    if (in_gap_odds != 0 && $urandom_range(0, 99) < in_gap_odds) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.range_front <= rd.front;
    in_if.range_right <= rd.right;
    in_if.range_back  <= rd.back;
    in_if.range_left  <= rd.left;
    in_if.enable_mask <= rd.mask;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tilt_q.push_back(known ? tilt : predict_tilt(rd));
    @(negedge clk_i);
  endtask

  // Entered and left at a falling edge; the caller lowers valid after the last write.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_START_THR: tilt_cfg.start_thr = data;
      REG_START_ANG: tilt_cfg.start_ang = data[ANG_W-1:0];
      REG_MID_THR:   tilt_cfg.mid_thr   = data;
      REG_MID_ANG:   tilt_cfg.mid_ang   = data[ANG_W-1:0];
      REG_MAX_THR:   tilt_cfg.max_thr   = data;
      REG_MAX_ANG:   tilt_cfg.max_ang   = data[ANG_W-1:0];
      REG_END_THR:   tilt_cfg.end_thr   = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (tilt_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    tilt_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.roll  = out_if.roll_angle;
      got.pitch = out_if.pitch_angle;
      if (tilt_q.size() == 0) begin
        $display("%0t: result with none expected: roll %0d pitch %0d",
                 $time, got.roll, got.pitch);
        mismatch_cnt++;
      end else begin
        want = tilt_q.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t: roll mismatch: expected %0d, actual %0d", $time, want.roll, got.roll);
          mismatch_cnt++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch mismatch: expected %0d, actual %0d",
                   $time, want.pitch, got.pitch);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, tilt_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off that lets the pipeline fill up.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (out_stall_odds != 0 && $urandom_range(0, 99) < out_stall_odds) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    reading_t              rd;
    int                    e_thr, x_thr, m_thr;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.range_front = '0;
    in_if.range_right = '0;
    in_if.range_back  = '0;
    in_if.range_left  = '0;
    in_if.enable_mask = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    tilt_cfg          = '{START_THR_RST, START_ANG_RST, MID_THR_RST, MID_ANG_RST,
                          MAX_THR_RST, MAX_ANG_RST, END_THR_RST};

    // Directed rows under the reset settings.
    add_row(0, 0, 0, 0, 4'hF, 1, 0, 0);
    add_row(65535, 65535, 65535, 65535, 4'hF, 1, 0, 0);
    add_row(300, 300, 300, 300, 4'h0, 1, 0, 0);
    add_row(300, 0, 0, 0, 4'h1, 1, 0, -80);
    add_row(0, 300, 0, 0, 4'h2, 1, -80, 0);
    add_row(0, 0, 300, 0, 4'h4, 1, 0, 80);
    add_row(0, 0, 0, 300, 4'h8, 1, 80, 0);
    add_row(300, 300, 300, 300, 4'hF, 1, 0, 0);
    add_row(20, 0, 0, 0, 4'h1, 1, 0, 0);
    add_row(21, 0, 0, 0, 4'h1, 1, 0, -80);
    add_row(2000, 0, 0, 0, 4'h1, 1, 0, 0);
    add_row(1999, 0, 0, 0, 4'h1, 1, 0, 0);
    add_row(1001, 0, 0, 0, 4'h1, 0, 0, 0);
    add_row(1000, 0, 0, 0, 4'h1, 1, 0, -40);
    add_row(401, 0, 0, 0, 4'h1, 0, 0, 0);
    add_row(400, 0, 0, 0, 4'h1, 1, 0, -80);
    add_row(0, 1500, 0, 700, 4'hA, 0, 0, 0);
    add_row(600, 0, 1200, 0, 4'h5, 0, 0, 0);
    add_row(1234, 567, 890, 1750, 4'hF, 0, 0, 0);
    add_row(100, 100, 65535, 0, 4'hF, 1, -80, -80);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    out_stall_odds = 20;
    in_gap_odds    = 20;
    foreach (dir_rows[i]) send_reading(dir_rows[i].rd, dir_rows[i].known, dir_rows[i].tilt);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        case (ph)
          1: vals = '{16'hFFFF, 16'hFFFF, 16'h8000, 16'd900, 16'd1000, 16'd900, 16'd0};
          2: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
          // Second ramp falls from start angle toward a smaller mid angle.
          3: vals = '{16'd3000, 16'd900, 16'd1500, 16'd100, 16'd500, 16'd300, 16'd50};
          // Thresholds out of order, so neither ramp is ever entered.
          4: vals = '{16'd1000, 16'd500, 16'd2000, 16'd800, 16'd3000, 16'd700, 16'd10};
          5: begin
            e_thr = $urandom_range(0, 200);
            x_thr = e_thr + $urandom_range(0, 2000);
            m_thr = x_thr + $urandom_range(0, 4000);
            vals  = '{CFG_DATA_W'(m_thr + $urandom_range(0, 8000)),
                      CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'(m_thr),
                      CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'(x_thr),
                      CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'(e_thr)};
          end
          6: foreach (vals[r]) vals[r] = CFG_DATA_W'($urandom);
          default: vals = '{START_THR_RST, CFG_DATA_W'(START_ANG_RST), MID_THR_RST,
                            CFG_DATA_W'(MID_ANG_RST), MAX_THR_RST,
                            CFG_DATA_W'(MAX_ANG_RST), END_THR_RST};
        endcase
        for (int r = REG_START_THR; r <= REG_END_THR; r++) write_reg(r[REG_IDX_W-1:0], vals[r]);
        // An index past the last register must leave every register alone.
        if (ph == 1) write_reg(REG_IDX_NONE, 16'h0123);
        cfg_if.valid <= 1'b0;
      end

      if (ph == NUM_PHASES - 1) begin
        in_gap_odds    = 0;
        out_stall_odds = 0;
      end else if (ph == 1) begin
        in_gap_odds    = 0;
        out_stall_odds = 20;
        hold_req       = 1'b1;
      end else begin
        in_gap_odds    = 20 * $urandom_range(0, 2);
        out_stall_odds = 20 * $urandom_range(0, 2);
      end

      repeat (ITEMS_PER_PHASE) begin
        rd.front = pick_range();
        rd.right = pick_range();
        rd.back  = pick_range();
        rd.left  = pick_range();
        rd.mask  = NUM_LANES'($urandom_range(0, 15));
        send_reading(rd, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (2 * LATENCY) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rtat_pkg.sv
sv/rtat_ifs.sv
sv/rtat_cfg_regs.sv
sv/rtat_lane.sv
sv/rtat_merge.sv
sv/range_to_avoidance_tilt_top.sv
dv/range_to_avoidance_tilt_top_tb.sv
